/* sv/mrdt_pkg.sv */
package mrdt_pkg;

	// Dead-time limits in millisecond ticks.
	localparam int unsigned MIN_DELAY_TICKS = 50;
	localparam int unsigned MAX_DELAY_TICKS = 300;
	localparam int unsigned DELAY_SPAN =
		(MAX_DELAY_TICKS > MIN_DELAY_TICKS) ? (MAX_DELAY_TICKS - MIN_DELAY_TICKS) : 0;

	localparam int unsigned SPEED_W     = 8;
	localparam int unsigned DUTY_W      = 8;
	localparam int unsigned WAIT_W      = 9;
	localparam int unsigned MAG_W       = 8;
	localparam int unsigned CLAMP_W     = 7;
	localparam logic [CLAMP_W-1:0] MAG_LIMIT = 7'd100;

	// Division by 100 is a multiplication by a rounded-up reciprocal and a shift.
	// With magnitudes of at most 128 the rounding error stays far below one step.
	localparam int unsigned RECIP_SHIFT = 23;
	localparam int unsigned DUTY_SCALE_W = 25;
	localparam int unsigned DEAD_SCALE_W = 26;
	localparam logic [63:0] DUTY_SCALE_64 =
		(64'd255 * (64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
	localparam logic [63:0] DEAD_SCALE_64 =
		(64'(DELAY_SPAN) * (64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
	localparam logic [DUTY_SCALE_W-1:0] DUTY_SCALE = DUTY_SCALE_64[DUTY_SCALE_W-1:0];
	localparam logic [DEAD_SCALE_W-1:0] DEAD_SCALE = DEAD_SCALE_64[DEAD_SCALE_W-1:0];

	localparam int unsigned DEAD_Q_W = 10;
	localparam int unsigned DEAD_SUM_W = 11;
	localparam logic [DEAD_SUM_W-1:0] MIN_DELAY = DEAD_SUM_W'(MIN_DELAY_TICKS);
	localparam logic [DEAD_SUM_W-1:0] MAX_DELAY = DEAD_SUM_W'(MAX_DELAY_TICKS);
	localparam logic SPAN_NONZERO = (DELAY_SPAN != 0);

	// Configuration port.
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam logic REG_REVERSE_MOTOR = 1'b0;

	typedef enum logic {
		OP_COMMAND = 1'b0,
		OP_TICK    = 1'b1
	} op_t;

endpackage

/* sv/motor_reversal_dead_time_drive_top.sv */
// H-bridge drive with a dead time on direction reversal.
// The item channel (item_valid, item_stall, operation, speed_command) carries either a
// signed speed command in percent or a one-millisecond tick. Every item yields exactly one
// result on the result channel (result_valid, result_stall, pwm_duty, direction_high,
// reversal_pending): the drive state after that item.
// A command whose sign opposes the last applied speed first drives zero speed and is
// held; it is applied on the tick after the dead time has run out. Zero or same-sign
// commands apply at once and cancel anything pending.
// The item lands in an input register, and the state update from it is loaded into the
// result register, from which the result is read. One item
// is accepted every cycle as long as the result side takes results; the path is one
// constant multiplier each for duty and dead time. When the receiver stalls, the result
// holds, the item held in the input register waits, and item_stall rises once that
// register is occupied.
// reverse_motor is written over APB at any address with paddr[2] low, by the user only
// while the block is idle (not enforced); it takes effect at the next applied speed.
// Reset clears the drive to zero duty, direction low, nothing pending, and empties both
// registers of the pipeline.
module motor_reversal_dead_time_drive_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mrdt_pkg::ADDR_W-1:0]        paddr,
	input  logic [mrdt_pkg::DATA_W-1:0]        pwdata,
	output logic [mrdt_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic                               operation,
	input  logic signed [mrdt_pkg::SPEED_W-1:0] speed_command,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [mrdt_pkg::DUTY_W-1:0]        pwm_duty,
	output logic                               direction_high,
	output logic                               reversal_pending
);

	logic                               reverse_q;
	logic                               valid_s1;
	logic                               operation_s1;
	logic signed [mrdt_pkg::SPEED_W-1:0] speed_s1;
	logic                               result_valid_q;
	logic signed [mrdt_pkg::SPEED_W-1:0] last_speed_q;
	logic signed [mrdt_pkg::SPEED_W-1:0] held_speed_q;
	logic [mrdt_pkg::WAIT_W-1:0]        wait_q;
	logic [mrdt_pkg::DUTY_W-1:0]        drive_duty_q;
	logic                               drive_dir_q;

	logic                               advance;
	logic                               is_tick;
	logic                               held_nz;
	logic                               opposite;
	logic                               apply_en;
	logic signed [mrdt_pkg::SPEED_W-1:0] apply_speed;
	logic [mrdt_pkg::MAG_W-1:0]         apply_mag;
	logic [mrdt_pkg::CLAMP_W-1:0]       apply_clamped;
	logic [mrdt_pkg::CLAMP_W+mrdt_pkg::DUTY_SCALE_W-1:0] duty_prod;
	logic [mrdt_pkg::DUTY_W-1:0]        duty_raw;
	logic                               fwd;
	logic [mrdt_pkg::DUTY_W-1:0]        duty_next;
	logic [mrdt_pkg::MAG_W-1:0]         last_mag;
	logic [mrdt_pkg::MAG_W+mrdt_pkg::DEAD_SCALE_W-1:0] dead_prod;
	logic [mrdt_pkg::DEAD_SUM_W-1:0]    dead_sum;
	logic [mrdt_pkg::WAIT_W-1:0]        dead_time;

	function automatic logic [mrdt_pkg::MAG_W-1:0] MAG_NEG(
		input logic signed [mrdt_pkg::SPEED_W-1:0] v
	);
		return mrdt_pkg::MAG_W'(-v);
	endfunction

	// Configuration port.
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[mrdt_pkg::ADDR_W-1] == mrdt_pkg::REG_REVERSE_MOTOR) begin
			prdata[0] = reverse_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
			paddr[mrdt_pkg::ADDR_W-1] == mrdt_pkg::REG_REVERSE_MOTOR) begin
			reverse_q <= pwdata[0];
		end
	end

	// The result register doubles as the drive state, so the state only moves when
	// the result slot is free.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			operation_s1 <= operation;
			speed_s1     <= speed_command;
		end
	end

	// Step logic.
	assign is_tick  = (operation_s1 == mrdt_pkg::OP_TICK);
	assign held_nz  = (held_speed_q != '0);
	assign opposite = (speed_s1 != '0) && (last_speed_q != '0) &&
		(speed_s1[mrdt_pkg::SPEED_W-1] != last_speed_q[mrdt_pkg::SPEED_W-1]);
	assign apply_en = !is_tick || (held_nz && wait_q == '0);

	always_comb begin
		if (is_tick) begin
			apply_speed = held_speed_q;
		end else if (opposite) begin
			apply_speed = '0;
		end else begin
			apply_speed = speed_s1;
		end
	end

	assign apply_mag = apply_speed[mrdt_pkg::SPEED_W-1] ? MAG_NEG(apply_speed) :
		mrdt_pkg::MAG_W'(apply_speed);
	assign apply_clamped = (apply_mag > mrdt_pkg::MAG_W'(mrdt_pkg::MAG_LIMIT)) ?
		mrdt_pkg::MAG_LIMIT : apply_mag[mrdt_pkg::CLAMP_W-1:0];
	assign duty_prod = (mrdt_pkg::CLAMP_W+mrdt_pkg::DUTY_SCALE_W)'(apply_clamped) *
		(mrdt_pkg::CLAMP_W+mrdt_pkg::DUTY_SCALE_W)'(mrdt_pkg::DUTY_SCALE);
	assign duty_raw  = duty_prod[mrdt_pkg::RECIP_SHIFT +: mrdt_pkg::DUTY_W];
	assign fwd       = !apply_speed[mrdt_pkg::SPEED_W-1] ^ reverse_q;
	assign duty_next = fwd ? ~duty_raw : duty_raw;

	// Dead time grows with the magnitude of the speed being reversed.
	assign last_mag = last_speed_q[mrdt_pkg::SPEED_W-1] ? MAG_NEG(last_speed_q) :
		mrdt_pkg::MAG_W'(last_speed_q);
	assign dead_prod = (mrdt_pkg::MAG_W+mrdt_pkg::DEAD_SCALE_W)'(last_mag) *
		(mrdt_pkg::MAG_W+mrdt_pkg::DEAD_SCALE_W)'(mrdt_pkg::DEAD_SCALE);
	assign dead_sum = mrdt_pkg::MIN_DELAY +
		mrdt_pkg::DEAD_SUM_W'(dead_prod[mrdt_pkg::RECIP_SHIFT +: mrdt_pkg::DEAD_Q_W]);
	assign dead_time = (mrdt_pkg::SPAN_NONZERO && dead_sum > mrdt_pkg::MAX_DELAY) ?
		mrdt_pkg::MAX_DELAY[mrdt_pkg::WAIT_W-1:0] : dead_sum[mrdt_pkg::WAIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			last_speed_q   <= '0;
			held_speed_q   <= '0;
			wait_q         <= '0;
			drive_duty_q   <= '0;
			drive_dir_q    <= 1'b0;
		end else begin
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (advance) begin
				if (apply_en) begin
					drive_duty_q <= duty_next;
					drive_dir_q  <= fwd;
				end
				if (is_tick) begin
					if (held_nz) begin
						if (wait_q == '0) begin
							last_speed_q <= held_speed_q;
							held_speed_q <= '0;
						end else begin
							wait_q <= wait_q - mrdt_pkg::WAIT_W'(1);
						end
					end
				end else if (opposite) begin
					held_speed_q <= speed_s1;
					wait_q       <= dead_time;
				end else begin
					last_speed_q <= speed_s1;
					held_speed_q <= '0;
					wait_q       <= '0;
				end
			end
		end
	end

	assign result_valid     = result_valid_q;
	assign pwm_duty         = drive_duty_q;
	assign direction_high   = drive_dir_q;
	assign reversal_pending = held_nz;

endmodule
